FILE: rtl/wsh_pkg.sv
package wsh_pkg;

    // reply buffer geometry
    localparam int unsigned REPLY_BYTES = 8;
    localparam int unsigned REPLY_IDX_W = $clog2(REPLY_BYTES);
    localparam int unsigned REPLY_CNT_W = REPLY_IDX_W + 1;

    // stream widths
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 16;

    // fill byte for a reply taken while data is not ready
    localparam logic [7:0] NOT_READY_FILL = 8'haa;
    // byte shown on a read past the reply length
    localparam logic [7:0] READ_PAST_END = 8'hff;
    // window length used when the register holds zero
    localparam logic [15:0] WINDOW_MIN = 16'd1;
    localparam logic [15:0] WINDOW_RESET = 16'd512;

    // event kinds carried on the input tuser
    typedef enum logic [2:0] {
        MODE_PINS      = 3'd0,
        MODE_TICK      = 3'd1,
        MODE_CONV_DONE = 3'd2,
        MODE_COMMAND   = 3'd3,
        MODE_READ      = 3'd4,
        MODE_ADDR      = 3'd5
    } mode_t;

    // bus commands
    localparam logic [7:0] CMD_POWER      = 8'd0;
    localparam logic [7:0] CMD_MEASURE    = 8'd1;
    localparam logic [7:0] CMD_READ_ALL   = 8'd2;
    localparam logic [7:0] CMD_STATUS     = 8'd3;
    localparam logic [7:0] CMD_CLEAR_RAIN = 8'd4;

    // converter channels
    localparam logic CHAN_UV        = 1'b0;
    localparam logic CHAN_DIRECTION = 1'b1;

    // one accepted input beat, unpacked
    typedef struct packed {
        logic        fire;
        mode_t       mode;
        logic        clock_pin;
        logic        rain_pin;
        logic        wind_pin;
        logic [9:0]  sample_value;
        logic [7:0]  command_byte;
    } event_t;

    // sensor side state and the per-beat result levels
    typedef struct packed {
        logic [15:0] rain_count;
        logic [15:0] wind_count;
        logic [9:0]  uv_value;
        logic [9:0]  direction_value;
        logic        ready_flag;
        logic        convert_start;
        logic        convert_channel;
        logic        ready_line;
        logic        data_ready;
    } sensor_status_t;

endpackage

FILE: rtl/wsh_sensor.sv
module wsh_sensor (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  wsh_pkg::event_t         evt,
    input  logic [15:0]             window_ticks,
    output wsh_pkg::sensor_status_t status
);

    logic [2:0]  prev_pins_reg, prev_pins_next;
    logic [15:0] rain_count_reg, rain_count_next;
    logic [15:0] wind_count_reg, wind_count_next;
    logic [9:0]  uv_value_reg, uv_value_next;
    logic [9:0]  direction_value_reg, direction_value_next;
    logic        ready_flag_reg, ready_flag_next;
    logic [15:0] window_left_reg, window_left_next;
    logic        pending_channel_reg, pending_channel_next;
    logic        notify_level_reg, notify_level_next;

    logic [2:0]  pins;
    logic        clock_fall;
    logic        rain_rise;
    logic        wind_rise;
    logic [15:0] window_dec;
    logic        conv_start;
    logic        conv_channel;

    assign pins       = {evt.wind_pin, evt.rain_pin, evt.clock_pin};
    assign clock_fall = prev_pins_reg[0] & ~pins[0];
    assign rain_rise  = ~prev_pins_reg[1] & pins[1];
    assign wind_rise  = ~prev_pins_reg[2] & pins[2];
    assign window_dec = window_left_reg - 16'd1;

    // next state for one event
    always_comb begin
        prev_pins_next       = prev_pins_reg;
        rain_count_next      = rain_count_reg;
        wind_count_next      = wind_count_reg;
        uv_value_next        = uv_value_reg;
        direction_value_next = direction_value_reg;
        ready_flag_next      = ready_flag_reg;
        window_left_next     = window_left_reg;
        pending_channel_next = pending_channel_reg;
        notify_level_next    = notify_level_reg;
        conv_start           = 1'b0;
        conv_channel         = wsh_pkg::CHAN_UV;
        case (evt.mode)
            wsh_pkg::MODE_PINS: begin
                prev_pins_next = pins;
                // clock fall opens a new window before wind edges are counted
                if (clock_fall) begin
                    pending_channel_next = wsh_pkg::CHAN_UV;
                    conv_start           = 1'b1;
                    wind_count_next      = 16'd0;
                    ready_flag_next      = 1'b0;
                    window_left_next     = (window_ticks == 16'd0) ? wsh_pkg::WINDOW_MIN
                                                                   : window_ticks;
                    notify_level_next    = 1'b0;
                end
                if (rain_rise) begin
                    rain_count_next = rain_count_reg + 16'd1;
                end
                if (wind_rise && (clock_fall || window_left_reg != 16'd0)) begin
                    wind_count_next = wind_count_next + 16'd1;
                end
            end
            wsh_pkg::MODE_TICK: begin
                if (window_left_reg != 16'd0) begin
                    window_left_next = window_dec;
                    if (window_dec == 16'd0) begin
                        ready_flag_next   = 1'b1;
                        notify_level_next = 1'b1;
                    end
                end
            end
            wsh_pkg::MODE_CONV_DONE: begin
                // uv result chains into a direction conversion
                if (pending_channel_reg == wsh_pkg::CHAN_UV) begin
                    uv_value_next        = evt.sample_value;
                    pending_channel_next = wsh_pkg::CHAN_DIRECTION;
                    conv_start           = 1'b1;
                    conv_channel         = wsh_pkg::CHAN_DIRECTION;
                end else begin
                    direction_value_next = evt.sample_value;
                end
            end
            wsh_pkg::MODE_COMMAND: begin
                if (evt.command_byte == wsh_pkg::CMD_MEASURE) begin
                    ready_flag_next      = 1'b0;
                    pending_channel_next = wsh_pkg::CHAN_UV;
                    conv_start           = 1'b1;
                end else if (evt.command_byte == wsh_pkg::CMD_CLEAR_RAIN) begin
                    rain_count_next = 16'd0;
                end
            end
            default: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pins_reg       <= 3'd0;
            rain_count_reg      <= 16'd0;
            wind_count_reg      <= 16'd0;
            uv_value_reg        <= 10'd0;
            direction_value_reg <= 10'd0;
            ready_flag_reg      <= 1'b0;
            window_left_reg     <= 16'd0;
            pending_channel_reg <= wsh_pkg::CHAN_UV;
            notify_level_reg    <= 1'b1;
        end else if (evt.fire) begin
            prev_pins_reg       <= prev_pins_next;
            rain_count_reg      <= rain_count_next;
            wind_count_reg      <= wind_count_next;
            uv_value_reg        <= uv_value_next;
            direction_value_reg <= direction_value_next;
            ready_flag_reg      <= ready_flag_next;
            window_left_reg     <= window_left_next;
            pending_channel_reg <= pending_channel_next;
            notify_level_reg    <= notify_level_next;
        end
    end

    // current values for the reply side, post-event levels for the result
    always_comb begin
        status.rain_count      = rain_count_reg;
        status.wind_count      = wind_count_reg;
        status.uv_value        = uv_value_reg;
        status.direction_value = direction_value_reg;
        status.ready_flag      = ready_flag_reg;
        status.convert_start   = conv_start;
        status.convert_channel = conv_channel;
        status.ready_line      = notify_level_next;
        status.data_ready      = ready_flag_next;
    end

endmodule

FILE: rtl/wsh_reply.sv
module wsh_reply (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  wsh_pkg::event_t         evt,
    input  wsh_pkg::sensor_status_t status,
    output logic [7:0]              read_data,
    output logic                    read_valid
);

    logic [7:0] reply_mem [wsh_pkg::REPLY_BYTES];

    logic [wsh_pkg::REPLY_CNT_W-1:0] reply_index_reg, reply_index_next;
    logic [wsh_pkg::REPLY_CNT_W-1:0] reply_length_reg, reply_length_next;
    logic                            powered_reg, powered_next;

    logic       is_command;
    logic       load_all;
    logic       load_first;
    logic [7:0] first_byte;
    logic       can_read;
    logic [7:0] image [wsh_pkg::REPLY_BYTES];

    assign is_command = evt.mode == wsh_pkg::MODE_COMMAND;
    assign can_read   = (reply_index_reg < reply_length_reg)
                        && (reply_index_reg[wsh_pkg::REPLY_IDX_W] == 1'b0);

    // full reply image, msb first: rain, wind, direction, uv; all fill bytes while not ready
    always_comb begin
        image[0] = status.rain_count[15:8];
        image[1] = status.rain_count[7:0];
        image[2] = status.wind_count[15:8];
        image[3] = status.wind_count[7:0];
        image[4] = {6'd0, status.direction_value[9:8]};
        image[5] = status.direction_value[7:0];
        image[6] = {6'd0, status.uv_value[9:8]};
        image[7] = status.uv_value[7:0];
        if (!status.ready_flag) begin
            for (int i = 0; i < wsh_pkg::REPLY_BYTES; i++) begin
                image[i] = wsh_pkg::NOT_READY_FILL;
            end
        end
    end

    // command decode and read pointer
    always_comb begin
        reply_index_next  = reply_index_reg;
        reply_length_next = reply_length_reg;
        powered_next      = powered_reg;
        load_all          = 1'b0;
        load_first        = 1'b0;
        first_byte        = 8'd0;
        read_data         = 8'd0;
        read_valid        = 1'b0;
        case (evt.mode)
            wsh_pkg::MODE_COMMAND: begin
                reply_index_next = '0;
                if (evt.command_byte == wsh_pkg::CMD_POWER) begin
                    load_first        = 1'b1;
                    first_byte        = {7'd0, powered_reg};
                    reply_length_next = wsh_pkg::REPLY_CNT_W'(1);
                    powered_next      = 1'b1;
                end else if (evt.command_byte == wsh_pkg::CMD_READ_ALL) begin
                    load_all          = 1'b1;
                    reply_length_next = wsh_pkg::REPLY_CNT_W'(wsh_pkg::REPLY_BYTES);
                end else if (evt.command_byte == wsh_pkg::CMD_STATUS) begin
                    load_first        = 1'b1;
                    first_byte        = {7'd0, status.ready_flag};
                    reply_length_next = wsh_pkg::REPLY_CNT_W'(1);
                end
            end
            wsh_pkg::MODE_READ: begin
                if (can_read) begin
                    read_data        = reply_mem[reply_index_reg[wsh_pkg::REPLY_IDX_W-1:0]];
                    read_valid       = 1'b1;
                    reply_index_next = reply_index_reg + wsh_pkg::REPLY_CNT_W'(1);
                end else begin
                    read_data = wsh_pkg::READ_PAST_END;
                end
            end
            wsh_pkg::MODE_ADDR: begin
                reply_index_next = '0;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reply_index_reg  <= '0;
            reply_length_reg <= '0;
            powered_reg      <= 1'b0;
        end else if (evt.fire) begin
            reply_index_reg  <= reply_index_next;
            reply_length_reg <= reply_length_next;
            powered_reg      <= powered_next;
        end
    end

    // reply buffer, no reset
    always_ff @(posedge aclk) begin
        if (evt.fire && is_command) begin
            if (load_all) begin
                for (int i = 0; i < wsh_pkg::REPLY_BYTES; i++) begin
                    reply_mem[i] <= image[i];
                end
            end else if (load_first) begin
                reply_mem[0] <= first_byte;
            end
        end
    end

endmodule

FILE: rtl/weather_sensor_hub_unit.sv
// channel  | dir | payload (lsb first)
// ---------+-----+---------------------------------------------------------
// s_       | in  | tuser: mode[2:0]
//          |     | tdata: clock_pin, rain_pin, wind_pin, sample_value[9:0],
//          |     |        command_byte[7:0], zero pad
// m_       | out | tdata: read_data[7:0], read_valid, convert_start,
//          |     |        convert_channel, ready_line, data_ready, zero pad
// cfg_     | in  | cfg_wr_data: window_ticks[15:0]
//
// one input beat per cycle while m_ is not stalled; its result beat is held in
// the output register and shows in the cycle after acceptance.
// input is taken whenever the output register is empty or being drained.
// aresetn is synchronous, active low, and restores every counter and flag;
// the reply buffer contents are not cleared.
// a stalled m_ side holds the result and back-pressures s_tready.
module weather_sensor_hub_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // clock_pin, rain_pin, wind_pin, sample_value[9:0], command_byte[7:0]
    input  logic [wsh_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[2:0]
    input  logic [wsh_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_data[7:0], read_valid, convert_start, convert_channel,
    // ready_line, data_ready
    output logic [wsh_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [15:0]                   cfg_wr_data
);

    wsh_pkg::event_t         evt;
    wsh_pkg::sensor_status_t status;

    logic [15:0] window_ticks_reg;
    logic        m_tvalid_reg;
    logic [wsh_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [7:0]  read_data;
    logic        read_valid;

    // input beat unpack
    assign s_tready = ~m_tvalid_reg | m_tready;

    always_comb begin
        evt.fire         = s_tvalid & s_tready;
        evt.mode         = wsh_pkg::mode_t'(s_tuser);
        evt.clock_pin    = s_tdata[0];
        evt.rain_pin     = s_tdata[1];
        evt.wind_pin     = s_tdata[2];
        evt.sample_value = s_tdata[12:3];
        evt.command_byte = s_tdata[20:13];
    end

    // window length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_ticks_reg <= wsh_pkg::WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_ticks_reg <= cfg_wr_data;
        end
    end

    wsh_sensor u_sensor (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .evt          (evt),
        .window_ticks (window_ticks_reg),
        .status       (status)
    );

    wsh_reply u_reply (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .evt        (evt),
        .status     (status),
        .read_data  (read_data),
        .read_valid (read_valid)
    );

    // result beat pack
    assign m_tdata_next = {3'd0, status.data_ready, status.ready_line,
                           status.convert_channel, status.convert_start,
                           read_valid, read_data};

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (evt.fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsh_pkg::*;

    // codes outside the defined event kinds, the block ignores them
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    // command codes outside the defined set
    localparam logic [7:0] CMD_FIRST_UNKNOWN = 8'd5;
    localparam logic [7:0] CMD_TOP = 8'hff;

    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_LIMIT = 2000;
    localparam int PHASE_EVENTS = 200;
    localparam int MAX_REPORTS = 40;

    // result beat, laid out as m_tdata[12:0]
    typedef struct packed {
        logic       data_ready;
        logic       ready_line;
        logic       convert_channel;
        logic       convert_start;
        logic       read_valid;
        logic [7:0] read_data;
    } hub_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [15:0]          cfg_wr_data = '0;

    weather_sensor_hub_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // hub state as the predictor sees it
    logic [2:0]  pin_last = '0;
    logic [15:0] rain_cnt = '0;
    logic [15:0] wind_cnt = '0;
    logic [9:0]  uv_reading = '0;
    logic [9:0]  dir_reading = '0;
    logic        ready_bit = 1'b0;
    logic [15:0] ticks_left = '0;
    logic        next_chan = CHAN_UV;
    logic        powered_bit = 1'b0;
    logic [7:0]  reply_buf [REPLY_BYTES];
    logic [3:0]  reply_ptr = '0;
    logic [3:0]  reply_len = '0;
    logic        notify_bit = 1'b1;
    logic [15:0] window_cfg = WINDOW_RESET;

    hub_result_t expected_results [$];
    int          fail_count = 0;
    int          events_sent = 0;
    int          results_seen = 0;
    int          windows_written = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          hold_req = 1'b0;

    initial begin
        foreach (reply_buf[i]) reply_buf[i] = '0;
    end

    // next hub state and result beat for one accepted event
    function automatic hub_result_t apply_event(logic [2:0] mode, logic [2:0] pins,
                                                logic [9:0] sample, logic [7:0] cmd);
        hub_result_t r;
        logic [2:0]  changed;
        r = '0;
        case (mode)
            MODE_PINS: begin
                changed = pins ^ pin_last;
                pin_last = pins;
                // clock fall first, so a wind rise in the same sample counts
                if (changed[0] && !pins[0]) begin
                    next_chan = CHAN_UV;
                    r.convert_start = 1'b1;
                    r.convert_channel = CHAN_UV;
                    wind_cnt = '0;
                    ready_bit = 1'b0;
                    ticks_left = (window_cfg == '0) ? WINDOW_MIN : window_cfg;
                    notify_bit = 1'b0;
                end
                if (changed[1] && pins[1])
                    rain_cnt = rain_cnt + 16'd1;
                if (changed[2] && pins[2] && ticks_left != '0)
                    wind_cnt = wind_cnt + 16'd1;
            end
            MODE_TICK: begin
                if (ticks_left != '0) begin
                    ticks_left = ticks_left - 16'd1;
                    if (ticks_left == '0) begin
                        ready_bit = 1'b1;
                        notify_bit = 1'b1;
                    end
                end
            end
            MODE_CONV_DONE: begin
                // stored by the channel last asked for, uv chains to direction
                if (next_chan == CHAN_UV) begin
                    uv_reading = sample;
                    next_chan = CHAN_DIRECTION;
                    r.convert_start = 1'b1;
                    r.convert_channel = CHAN_DIRECTION;
                end else begin
                    dir_reading = sample;
                end
            end
            MODE_COMMAND: begin
                case (cmd)
                    CMD_POWER: begin
                        reply_buf[0] = {7'b0, powered_bit};
                        reply_len = 4'd1;
                        powered_bit = 1'b1;
                    end
                    CMD_MEASURE: begin
                        ready_bit = 1'b0;
                        next_chan = CHAN_UV;
                        r.convert_start = 1'b1;
                        r.convert_channel = CHAN_UV;
                    end
                    CMD_READ_ALL: begin
                        if (ready_bit) begin
                            reply_buf[0] = rain_cnt[15:8];
                            reply_buf[1] = rain_cnt[7:0];
                            reply_buf[2] = wind_cnt[15:8];
                            reply_buf[3] = wind_cnt[7:0];
                            reply_buf[4] = {6'b0, dir_reading[9:8]};
                            reply_buf[5] = dir_reading[7:0];
                            reply_buf[6] = {6'b0, uv_reading[9:8]};
                            reply_buf[7] = uv_reading[7:0];
                        end else begin
                            foreach (reply_buf[i]) reply_buf[i] = NOT_READY_FILL;
                        end
                        reply_len = 4'(REPLY_BYTES);
                    end
                    CMD_STATUS: begin
                        reply_buf[0] = {7'b0, ready_bit};
                        reply_len = 4'd1;
                    end
                    CMD_CLEAR_RAIN: rain_cnt = '0;
                    default: ;
                endcase
                reply_ptr = '0;
            end
            MODE_READ: begin
                if (reply_ptr < reply_len) begin
                    r.read_data = reply_buf[reply_ptr];
                    r.read_valid = 1'b1;
                    reply_ptr = reply_ptr + 4'd1;
                end else begin
                    r.read_data = READ_PAST_END;
                end
            end
            MODE_ADDR: reply_ptr = '0;
            default: ;
        endcase
        r.ready_line = notify_bit;
        r.data_ready = ready_bit;
        return r;
    endfunction

    function automatic void flag_error(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $error("%s", msg);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
            flag_error($sformatf("%s: expected 0x%0h, actual 0x%0h", name, want, got));
    endfunction

    // result checker, one beat per handshake
    always @(posedge aclk) begin
        hub_result_t got;
        hub_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = hub_result_t'(m_tdata[12:0]);
            results_seen++;
            if (expected_results.size() == 0) begin
                flag_error($sformatf("result beat 0x%0h with none expected", m_tdata));
            end else begin
                want = expected_results.pop_front();
                check_field("read_data", want.read_data, got.read_data);
                check_field("read_valid", want.read_valid, got.read_valid);
                check_field("convert_start", want.convert_start, got.convert_start);
                check_field("convert_channel", want.convert_channel, got.convert_channel);
                check_field("ready_line", want.ready_line, got.ready_line);
                check_field("data_ready", want.data_ready, got.data_ready);
            end
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // send one event beat; fields the mode does not use carry random bits
    task automatic send_event(input logic [2:0] mode, input logic [31:0] arg);
        logic [2:0] pins;
        logic [9:0] sample;
        logic [7:0] cmd;
        pins = 3'($urandom);
        sample = 10'($urandom);
        cmd = 8'($urandom);
        case (mode)
            MODE_PINS:      pins = arg[2:0];
            MODE_CONV_DONE: sample = arg[9:0];
            MODE_COMMAND:   cmd = arg[7:0];
            default: ;
        endcase
        @(negedge aclk);
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {3'b000, cmd, sample, pins};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(apply_event(mode, pins, sample, cmd));
        events_sent++;
    endtask

    // stop offering beats and wait for every result to come back
    task automatic settle();
        int guard;
        guard = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (expected_results.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", expected_results.size()));
            expected_results.delete();
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_window(input logic [15:0] ticks);
        settle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ticks;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        window_cfg = ticks;
        windows_written++;
    endtask

    task automatic random_event();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            send_event(MODE_PINS, $urandom_range(0, 7));
        else if (pick < 50)
            send_event(MODE_TICK, 0);
        else if (pick < 58)
            send_event(MODE_CONV_DONE, $urandom_range(0, 1023));
        else if (pick < 72)
            send_event(MODE_COMMAND, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                     : $urandom_range(CMD_POWER, CMD_CLEAR_RAIN));
        else if (pick < 93)
            send_event(MODE_READ, 0);
        else if (pick < 97)
            send_event(MODE_ADDR, 0);
        else
            send_event(3'($urandom_range(MODE_SPARE_A, MODE_SPARE_B)), 0);
    endtask

    // full measuring cycle: clock fall, both conversions, wind pulses, readout
    task automatic measure_cycle();
        int n;
        n = (window_cfg == '0) ? 1 : ((window_cfg > 16'd12) ? 12 : int'(window_cfg));
        send_event(MODE_PINS, ($urandom_range(0, 3) << 1) | 1);
        send_event(MODE_PINS, $urandom_range(0, 3) << 1);
        send_event(MODE_CONV_DONE, $urandom_range(0, 1023));
        send_event(MODE_CONV_DONE, $urandom_range(0, 1023));
        repeat (n) begin
            send_event(MODE_PINS, 4 | ($urandom_range(0, 1) << 1));
            send_event(MODE_PINS, $urandom_range(0, 1) << 1);
            send_event(MODE_TICK, 0);
        end
        send_event(MODE_COMMAND, CMD_READ_ALL);
        repeat (REPLY_BYTES) send_event(MODE_READ, 0);
    endtask

    // reads with an empty reply, ignored kinds, closed-window tick, unasked conversions
    task automatic test_idle_events();
        send_event(MODE_READ, 0);
        send_event(MODE_ADDR, 0);
        send_event(MODE_SPARE_A, 0);
        send_event(MODE_SPARE_B, 0);
        send_event(MODE_TICK, 0);
        send_event(MODE_CONV_DONE, 10'h155);
        send_event(MODE_CONV_DONE, 10'h2aa);
        settle();
    endtask

    // every command, reply reads, read past the end, index rewind
    task automatic test_commands();
        send_event(MODE_COMMAND, CMD_POWER);
        send_event(MODE_READ, 0);
        send_event(MODE_READ, 0);
        send_event(MODE_COMMAND, CMD_POWER);
        send_event(MODE_READ, 0);
        send_event(MODE_COMMAND, CMD_STATUS);
        send_event(MODE_COMMAND, CMD_READ_ALL);
        send_event(MODE_READ, 0);
        send_event(MODE_READ, 0);
        send_event(MODE_ADDR, 0);
        send_event(MODE_READ, 0);
        send_event(MODE_COMMAND, CMD_MEASURE);
        send_event(MODE_COMMAND, CMD_CLEAR_RAIN);
        send_event(MODE_COMMAND, CMD_FIRST_UNKNOWN);
        send_event(MODE_COMMAND, CMD_TOP);
        settle();
    endtask

    // zero window, clock fall with rain and wind in one sample, widest window
    task automatic test_measure_window();
        write_window(16'd0);
        send_event(MODE_PINS, 3'b001);
        send_event(MODE_PINS, 3'b110);
        send_event(MODE_CONV_DONE, 10'h3ff);
        send_event(MODE_CONV_DONE, 10'h000);
        send_event(MODE_TICK, 0);
        send_event(MODE_COMMAND, CMD_READ_ALL);
        repeat (REPLY_BYTES + 1) send_event(MODE_READ, 0);
        write_window(16'hffff);
        send_event(MODE_PINS, 3'b001);
        send_event(MODE_PINS, 3'b000);
        send_event(MODE_TICK, 0);
        send_event(MODE_COMMAND, CMD_STATUS);
        send_event(MODE_READ, 0);
        write_window(16'd1);
    endtask

    // receiver holds off long enough that the input side stalls
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (24) random_event();
        settle();
    endtask

    // random traffic over several window settings, the last phase without idling
    task automatic test_random_traffic();
        int start;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_window(16'd1);
                1: write_window(16'($urandom_range(2, 8)));
                2: write_window(16'hffff);
                3: write_window(16'($urandom_range(1, 16)));
                4: write_window(16'd0);
                default: write_window(16'($urandom_range(2, 6)));
            endcase
            src_idle_on = (phase < 5);
            sink_idle_on = (phase < 5);
            start = events_sent;
            while (events_sent - start < PHASE_EVENTS) begin
                if ($urandom_range(0, 9) < 2)
                    measure_cycle();
                else
                    random_event();
            end
        end
        settle();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_events();
        test_commands();
        test_measure_window();
        test_backpressure();
        test_random_traffic();
        $display("run: %0d event beats sent, %0d result beats checked, %0d window writes",
                 events_sent, results_seen, windows_written);
        $display("run: all event kinds and commands, window settings, long receiver hold");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

endmodule
